@@ hw/rtl/pfde_pkg.sv @@
// Shared types, opcodes and the 5x7 glyph table for the framebuffer draw engine.
package pfde_pkg;

  localparam logic [2:0] OP_READ   = 3'd0;
  localparam logic [2:0] OP_FILL   = 3'd1;
  localparam logic [2:0] OP_PIXEL  = 3'd2;
  localparam logic [2:0] OP_CHAR   = 3'd3;
  localparam logic [2:0] OP_RECT   = 3'd4;
  localparam logic [2:0] OP_HLINE  = 3'd5;
  localparam logic [2:0] OP_CIRCLE = 3'd6;

  localparam logic [7:0] GLYPH_FIRST = 8'd32;
  localparam logic [7:0] GLYPH_LAST  = 8'd126;

  // One pixel write request from the sequencer to the framebuffer port.
  typedef struct packed {
    logic       vld;
    logic [7:0] x;
    logic [7:0] y;
    logic       on;
  } plot_req_t;

  // Glyph column bits; index is code - 32.
  function automatic logic [7:0] glyph_col(input logic [6:0] idx, input logic [2:0] col);
    logic [39:0] g;
    begin
      unique case (idx)
        7'd0:  g = 40'h0000000000; 7'd1:  g = 40'h00005F0000; 7'd2:  g = 40'h0007000700;
        7'd3:  g = 40'h147F147F14; 7'd4:  g = 40'h242A7F2A12; 7'd5:  g = 40'h2313086462;
        7'd6:  g = 40'h3649552250; 7'd7:  g = 40'h0005030000; 7'd8:  g = 40'h001C224100;
        7'd9:  g = 40'h0041221C00; 7'd10: g = 40'h14083E0814; 7'd11: g = 40'h08083E0808;
        7'd12: g = 40'h0050300000; 7'd13: g = 40'h0808080808; 7'd14: g = 40'h0060600000;
        7'd15: g = 40'h2010080402; 7'd16: g = 40'h3E5149453E; 7'd17: g = 40'h00427F4000;
        7'd18: g = 40'h4261514946; 7'd19: g = 40'h2141454B31; 7'd20: g = 40'h1814127F10;
        7'd21: g = 40'h2745454539; 7'd22: g = 40'h3C4A494930; 7'd23: g = 40'h0171090503;
        7'd24: g = 40'h3649494936; 7'd25: g = 40'h064949291E; 7'd26: g = 40'h0036360000;
        7'd27: g = 40'h0056360000; 7'd28: g = 40'h0814224100; 7'd29: g = 40'h1414141414;
        7'd30: g = 40'h0041221408; 7'd31: g = 40'h0201510906; 7'd32: g = 40'h324979413E;
        7'd33: g = 40'h7E1111117E; 7'd34: g = 40'h7F49494936; 7'd35: g = 40'h3E41414122;
        7'd36: g = 40'h7F4141221C; 7'd37: g = 40'h7F49494941; 7'd38: g = 40'h7F09090901;
        7'd39: g = 40'h3E4149497A; 7'd40: g = 40'h7F0808087F; 7'd41: g = 40'h00417F4100;
        7'd42: g = 40'h2040413F01; 7'd43: g = 40'h7F08142241; 7'd44: g = 40'h7F40404040;
        7'd45: g = 40'h7F020C027F; 7'd46: g = 40'h7F0408107F; 7'd47: g = 40'h3E4141413E;
        7'd48: g = 40'h7F09090906; 7'd49: g = 40'h3E4151215E; 7'd50: g = 40'h7F09192946;
        7'd51: g = 40'h4649494931; 7'd52: g = 40'h01017F0101; 7'd53: g = 40'h3F4040403F;
        7'd54: g = 40'h1F2040201F; 7'd55: g = 40'h3F4038403F; 7'd56: g = 40'h6314081463;
        7'd57: g = 40'h0708700807; 7'd58: g = 40'h6151494543; 7'd59: g = 40'h007F414100;
        7'd60: g = 40'h0204081020; 7'd61: g = 40'h0041417F00; 7'd62: g = 40'h0402010204;
        7'd63: g = 40'h4040404040; 7'd64: g = 40'h0001020400; 7'd65: g = 40'h2054545478;
        7'd66: g = 40'h7F48444438; 7'd67: g = 40'h3844444420; 7'd68: g = 40'h384444487F;
        7'd69: g = 40'h3854545418; 7'd70: g = 40'h087E090102; 7'd71: g = 40'h0C5252523E;
        7'd72: g = 40'h7F08040478; 7'd73: g = 40'h00447D4000; 7'd74: g = 40'h2040443D00;
        7'd75: g = 40'h7F10284400; 7'd76: g = 40'h00417F4000; 7'd77: g = 40'h7C04180478;
        7'd78: g = 40'h7C08040478; 7'd79: g = 40'h3844444438; 7'd80: g = 40'h7C14141408;
        7'd81: g = 40'h081414187C; 7'd82: g = 40'h7C08040408; 7'd83: g = 40'h4854545420;
        7'd84: g = 40'h043F444020; 7'd85: g = 40'h3C4040207C; 7'd86: g = 40'h1C2040201C;
        7'd87: g = 40'h3C4030403C; 7'd88: g = 40'h4428102844; 7'd89: g = 40'h0C5050503C;
        7'd90: g = 40'h4464544C44; 7'd91: g = 40'h0008364100; 7'd92: g = 40'h00007F0000;
        7'd93: g = 40'h0041360800; 7'd94: g = 40'h0C020C020C;
        default: g = 40'h0000000000;
      endcase
      case (col)
        3'd0: glyph_col = g[39:32];
        3'd1: glyph_col = g[31:24];
        3'd2: glyph_col = g[23:16];
        3'd3: glyph_col = g[15:8];
        default: glyph_col = g[7:0];
      endcase
    end
  endfunction

endpackage

@@ hw/rtl/pfde_fb.sv @@
// Framebuffer memory with read-modify-write pixel port, clear/fill sweep and byte read.
module pfde_fb #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pfde_pkg::plot_req_t plot,
  input  logic                sweep_vld,
  input  logic [$clog2(SCREEN_WIDTH*((SCREEN_HEIGHT+7)/8))-1:0] sweep_addr,
  input  logic                sweep_on,
  input  logic                rd_vld,
  input  logic [7:0]          rd_x,
  input  logic [7:0]          rd_page,
  output logic [7:0]          rd_data,
  output logic                busy
);
  localparam int PAGES = (SCREEN_HEIGHT + 7) / 8;
  localparam int DEPTH = SCREEN_WIDTH * PAGES;
  localparam int AW    = $clog2(DEPTH);

  logic [7:0] mem [DEPTH];

  // Stage 1: register address/bit for the read-modify-write
  logic          p1_vld_r;
  logic [AW-1:0] p1_addr_r;
  logic [2:0]    p1_bit_r;
  logic          p1_on_r;
  logic [7:0]    p1_data_r;
  logic          hit;
  logic [AW-1:0] p_addr;
  logic [AW-1:0] r_addr;
  logic          r_ok;
  logic [7:0]    merged;

  assign hit = plot.vld && ({1'b0, plot.x} < 9'(SCREEN_WIDTH))
                        && ({1'b0, plot.y} < 9'(SCREEN_HEIGHT));
  assign p_addr = AW'(32'(plot.x) + 32'(plot.y[7:3]) * 32'(SCREEN_WIDTH));
  assign r_ok   = ({1'b0, rd_x} < 9'(SCREEN_WIDTH)) && ({1'b0, rd_page} < 9'(PAGES));
  assign r_addr = AW'(32'(rd_x) + 32'(rd_page) * 32'(SCREEN_WIDTH));
  assign busy   = p1_vld_r;

  always_comb begin
    merged = p1_data_r;
    merged[p1_bit_r] = p1_on_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else begin
      p1_vld_r <= hit;
    end
    p1_addr_r <= p_addr;
    p1_bit_r  <= plot.y[2:0];
    p1_on_r   <= plot.on;
  end

  // Memory: two read addresses (pixel and byte read), one write (merge or sweep).
  // A pixel hitting the byte still being merged takes the merged value.
  always_ff @(posedge clk) begin
    if (hit) begin
      p1_data_r <= (p1_vld_r && (p1_addr_r == p_addr)) ? merged : mem[p_addr];
    end
    if (rd_vld) begin
      rd_data <= r_ok ? mem[r_addr] : 8'h00;
    end
    if (sweep_vld) begin
      mem[sweep_addr] <= sweep_on ? 8'hFF : 8'h00;
    end else if (p1_vld_r) begin
      mem[p1_addr_r] <= merged;
    end
  end
endmodule

@@ hw/rtl/pfde_seq.sv @@
// Command sequencer: walks each drawing command and issues at most one pixel per cycle.
module pfde_seq #(
  parameter int DEPTH = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [2:0]          op,
  input  logic [7:0]          px,
  input  logic [7:0]          py,
  input  logic [7:0]          ew,
  input  logic [7:0]          eh,
  input  logic [7:0]          ex,
  input  logic [7:0]          rr,
  input  logic [7:0]          cc,
  input  logic [7:0]          sc,
  input  logic                on,
  input  logic                fb_busy,
  output pfde_pkg::plot_req_t plot,
  output logic                sweep_vld,
  output logic [$clog2(DEPTH)-1:0] sweep_addr,
  output logic                sweep_on,
  output logic                done
);
  localparam int AW = $clog2(DEPTH);
  localparam logic [3:0] S_IDLE = 4'd0, S_SWEEP = 4'd1, S_PIX = 4'd2, S_GLY = 4'd3,
                         S_RH = 4'd4, S_RV = 4'd5, S_LINE = 4'd6, S_CIR = 4'd7,
                         S_CMUL = 4'd8, S_DRAIN = 4'd9;

  logic [3:0]  st_r, st_nxt;
  logic [AW:0] sw_r;
  logic        sw_on_r;
  logic [7:0]  x0_r, y0_r, x1_r, y1_r, sc_r;
  logic [7:0]  rr_r;
  logic [6:0]  gi_r;
  logic [2:0]  gc_r, gr_r;
  logic [7:0]  dx_r, dy_r;
  logic [15:0] ox_r, oy_r;          // glyph col*scale, row*scale
  logic        side_r;
  logic [8:0]  i_r;
  logic signed [9:0] cdx_r, cdy_r;
  logic [16:0] r2_r;
  logic [17:0] dsq_r;               // registered squared distance for the circle compare
  logic [7:0]  gbits;
  logic signed [10:0] cx, cy;
  logic        blk_last;
  logic        rx_ok, ry_ok;

  assign gbits = pfde_pkg::glyph_col(gi_r, gc_r);
  assign cx = 11'(signed'({1'b0, x0_r})) + 11'(cdx_r);
  assign cy = 11'(signed'({1'b0, y0_r})) + 11'(cdy_r);
  assign sweep_vld  = (st_r == S_SWEEP);
  assign sweep_addr = sw_r[AW-1:0];
  assign sweep_on   = sw_on_r;
  // Glyph bit finished: clear bit, or last pixel of its scale block
  assign blk_last = !gbits[gr_r] || (dx_r == sc_r - 1'b1 && dy_r == sc_r - 1'b1);
  // Rectangle spans that do not wrap past 255
  assign rx_ok = ({1'b0, px} + {1'b0, ew}) <= 9'd255;
  assign ry_ok = ({1'b0, py} + {1'b0, eh}) <= 9'd255;

  // Pixel issue decode
  always_comb begin
    plot = '0;
    plot.on = 1'b1;
    unique case (st_r)
      S_PIX: begin
        plot.vld = 1'b1; plot.x = x0_r; plot.y = y0_r; plot.on = sw_on_r;
      end
      S_GLY: begin
        plot.vld = gbits[gr_r];
        plot.x = x0_r + ox_r[7:0] + dx_r;
        plot.y = y0_r + oy_r[7:0] + dy_r;
      end
      S_RH: begin
        plot.vld = 1'b1; plot.x = i_r[7:0]; plot.y = side_r ? y1_r : y0_r;
      end
      S_RV: begin
        plot.vld = 1'b1; plot.x = side_r ? x1_r : x0_r; plot.y = i_r[7:0];
      end
      S_LINE: begin
        plot.vld = 1'b1; plot.x = i_r[7:0]; plot.y = y0_r;
      end
      S_CIR: begin
        plot.vld = (dsq_r <= 18'(r2_r)) && (cx >= 0) && (cy >= 0);
        plot.x = cx[7:0]; plot.y = cy[7:0];
      end
      default: plot.vld = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_SWEEP;
      sw_r    <= '0;
      sw_on_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (start) begin
        sw_r <= '0; sw_on_r <= on;
      end else if (st_r == S_SWEEP) begin
        sw_r <= sw_r + 1'b1;
      end
    end
  end

  always_comb begin
    st_nxt = st_r;
    done   = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        if (start) begin
          case (op)
            pfde_pkg::OP_FILL:   st_nxt = S_SWEEP;
            pfde_pkg::OP_PIXEL:  st_nxt = S_PIX;
            pfde_pkg::OP_CHAR:   st_nxt = S_GLY;
            pfde_pkg::OP_RECT:   st_nxt = rx_ok ? S_RH : (ry_ok ? S_RV : S_DRAIN);
            pfde_pkg::OP_HLINE:  st_nxt = (ex >= px) ? S_LINE : S_DRAIN;
            pfde_pkg::OP_CIRCLE: st_nxt = S_CMUL;
            default:             st_nxt = S_DRAIN;
          endcase
        end
      end
      S_SWEEP: if (sw_r == (AW+1)'(DEPTH - 1)) st_nxt = S_DRAIN;
      S_PIX:   st_nxt = S_DRAIN;
      S_GLY:   if (gc_r == 3'd4 && gr_r == 3'd7 && blk_last) st_nxt = S_DRAIN;
      S_RH:    if (side_r && (i_r >= {1'b0, x1_r}))
                 st_nxt = (y1_r >= y0_r) ? S_RV : S_DRAIN;
      S_RV:    if (side_r && (i_r >= {1'b0, y1_r})) st_nxt = S_DRAIN;
      S_LINE:  if (i_r >= {1'b0, x1_r}) st_nxt = S_DRAIN;
      S_CMUL:  st_nxt = S_CIR;
      S_CIR:   st_nxt = (cdx_r == 10'(rr_r) && cdy_r == 10'(rr_r)) ? S_DRAIN : S_CMUL;
      S_DRAIN: if (!fb_busy && !plot.vld) begin
                 st_nxt = S_IDLE; done = 1'b1;
               end
      default: st_nxt = S_IDLE;
    endcase
  end

  // Per-command loop counters
  always_ff @(posedge clk) begin
    if (start) begin
      x0_r <= px; y0_r <= py;
      x1_r <= (op == pfde_pkg::OP_HLINE) ? ex : px + ew;
      y1_r <= py + eh;
      sc_r <= (sc == 8'd0) ? 8'd1 : sc;
      rr_r <= rr;
      gi_r <= (cc >= pfde_pkg::GLYPH_FIRST && cc <= pfde_pkg::GLYPH_LAST) ?
              7'(cc - pfde_pkg::GLYPH_FIRST) : 7'd0;
      gc_r <= '0; gr_r <= '0; dx_r <= '0; dy_r <= '0; ox_r <= '0; oy_r <= '0;
      i_r  <= (op == pfde_pkg::OP_RECT && !rx_ok) ? {1'b0, py} : {1'b0, px};
      side_r <= 1'b0;
      cdx_r <= -10'(rr); cdy_r <= -10'(rr);
      r2_r  <= 17'(rr * rr);
    end else begin
      unique case (st_r)
        S_GLY: begin
          if (gbits[gr_r] && !(dx_r == sc_r - 1'b1 && dy_r == sc_r - 1'b1)) begin
            if (dy_r == sc_r - 1'b1) begin dy_r <= '0; dx_r <= dx_r + 1'b1; end
            else dy_r <= dy_r + 1'b1;
          end else begin
            dx_r <= '0; dy_r <= '0;
            if (gr_r == 3'd7) begin
              gr_r <= '0; oy_r <= '0; gc_r <= gc_r + 1'b1; ox_r <= ox_r + 16'(sc_r);
            end else begin
              gr_r <= gr_r + 1'b1; oy_r <= oy_r + 16'(sc_r);
            end
          end
        end
        S_RH: begin
          if (!side_r) side_r <= 1'b1;
          else begin
            side_r <= 1'b0;
            if (i_r >= {1'b0, x1_r}) i_r <= {1'b0, y0_r};
            else i_r <= i_r + 1'b1;
          end
        end
        S_RV: begin
          if (!side_r) side_r <= 1'b1;
          else begin side_r <= 1'b0; i_r <= i_r + 1'b1; end
        end
        S_LINE: i_r <= i_r + 1'b1;
        S_CMUL: dsq_r <= 18'(cdx_r * cdx_r) + 18'(cdy_r * cdy_r);
        S_CIR: begin
          if (cdx_r == 10'(rr_r)) begin cdx_r <= -10'(rr_r); cdy_r <= cdy_r + 1'b1; end
          else cdx_r <= cdx_r + 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule

@@ hw/rtl/page_framebuffer_draw_engine.sv @@
// Top level of the monochrome page framebuffer draw engine.
// Usage: one command per in_ request (in_valid/in_ready); each command answers
// with exactly one out_ request carrying out_read_data and out_was_read.
// in_ready is high only while the engine is idle and no result is pending, so
// one command is in flight at a time.
// Work per command: a fill sweeps every framebuffer byte (1024 by default);
// lines and rectangles step through their plotted pixels; a glyph steps through
// each glyph bit, and through a scale-by-scale block for each set bit; a filled
// circle visits every point of its (2r+1)^2 bounding square, alternating a
// squared-distance multiply state with a compare-and-plot state on its result.
// Pixel writes run through a pipelined read-modify-write port of the single
// framebuffer memory that can take a pixel before the last one is written.
// Reset: a clearing pass writes zero to every one of the SCREEN_WIDTH *
// ceil(SCREEN_HEIGHT/8) bytes, one a cycle, while in_ready stays low.
// A stalled receiver holds the result in the output register; the next command
// waits until it is taken.
module page_framebuffer_draw_engine #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_operation,
  input  logic [7:0] in_pos_x,
  input  logic [7:0] in_pos_y,
  input  logic [7:0] in_extent_w,
  input  logic [7:0] in_extent_h,
  input  logic [7:0] in_end_x,
  input  logic [7:0] in_radius,
  input  logic [7:0] in_char_code,
  input  logic [7:0] in_scale,
  input  logic       in_color,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_read_data,
  output logic       out_was_read
);
  localparam int DEPTH = SCREEN_WIDTH * ((SCREEN_HEIGHT + 7) / 8);
  localparam int AW    = $clog2(DEPTH);

  pfde_pkg::plot_req_t plot;
  logic          sweep_vld, sweep_on, fb_busy, done, start, busy_r, init_r;
  logic [AW-1:0] sweep_addr;
  logic [7:0]    rd_data;
  logic          is_rd_r;

  assign start    = in_valid && in_ready;
  assign in_ready = !busy_r && !out_valid && !init_r;

  pfde_fb #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_fb (
    .clk, .rst_n, .plot, .sweep_vld, .sweep_addr, .sweep_on,
    .rd_vld(start && in_operation == pfde_pkg::OP_READ),
    .rd_x(in_pos_x), .rd_page(in_pos_y), .rd_data, .busy(fb_busy)
  );

  pfde_seq #(.DEPTH(DEPTH)) u_seq (
    .clk, .rst_n, .start, .op(in_operation), .px(in_pos_x), .py(in_pos_y),
    .ew(in_extent_w), .eh(in_extent_h), .ex(in_end_x), .rr(in_radius),
    .cc(in_char_code), .sc(in_scale), .on(in_color),
    .fb_busy, .plot, .sweep_vld, .sweep_addr, .sweep_on, .done
  );

  // Busy / init tracking and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      init_r    <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (done) init_r <= 1'b0;
      if (start) busy_r <= 1'b1;
      else if (done && busy_r) busy_r <= 1'b0;
      if (done && busy_r) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
    if (start) is_rd_r <= (in_operation == pfde_pkg::OP_READ);
  end

  assign out_was_read  = is_rd_r;
  assign out_read_data = is_rd_r ? rd_data : 8'h00;

  // No new command while a result is outstanding
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("accept while result pending");
  // A result appears only after a command in flight
  a_res_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(busy_r)) else $error("spurious result");
  // Sweep never overlaps pixel issue
  a_sweep_excl: assert property (@(posedge clk) disable iff (!rst_n)
    sweep_vld |-> !plot.vld) else $error("sweep and plot together");
endmodule

@@ tb/sv/page_framebuffer_draw_engine_tb.sv @@
// Testbench for the page framebuffer draw engine: directed and random commands against a framebuffer predictor.
`timescale 1ns / 1ps
module page_framebuffer_draw_engine_tb;

  localparam int SCR_W      = 128;
  localparam int SCR_H      = 64;
  localparam int PAGES      = (SCR_H + 7) / 8;
  localparam int FB_BYTES   = SCR_W * PAGES;
  localparam int CYCLE_CAP  = 12_000_000;
  localparam int RAND_CMDS  = 1130;
  localparam logic [2:0] OP_NONE = 3'd7;

  // 5x7 font, one 40-bit word per glyph, column 0 in the top byte
  localparam logic [39:0] FONT [95] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14, 40'h242A7F2A12,
    40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001C224100, 40'h0041221C00,
    40'h14083E0814, 40'h08083E0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
    40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936,
    40'h064949291E, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
    40'h0041221408, 40'h0201510906, 40'h324979413E, 40'h7E1111117E, 40'h7F49494936,
    40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
    40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
    40'h7F09192946, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
    40'h3F4038403F, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040, 40'h0001020400,
    40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F, 40'h3854545418,
    40'h087E090102, 40'h0C5252523E, 40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
    40'h7F10284400, 40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
    40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
    40'h4464544C44, 40'h0008364100, 40'h00007F0000, 40'h0041360800, 40'h0C020C020C
  };

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] x, y, w, h, ex, r, code, sc;
    logic       color;
  } draw_cmd_t;

  typedef struct packed {
    logic [7:0] data;
    logic       rd;
  } read_reply_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] in_operation = '0;
  logic [7:0] in_pos_x = '0, in_pos_y = '0, in_extent_w = '0, in_extent_h = '0;
  logic [7:0] in_end_x = '0, in_radius = '0, in_char_code = '0, in_scale = '0;
  logic       in_color = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_read_data;
  logic       out_was_read;

  int  err_count = 0;
  int  cycle_count = 0;
  int  reads_seen = 0;
  int  replies_seen = 0;
  bit  long_hold = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  page_framebuffer_draw_engine u_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_operation, .in_pos_x, .in_pos_y,
    .in_extent_w, .in_extent_h, .in_end_x, .in_radius, .in_char_code, .in_scale,
    .in_color, .out_valid, .out_ready, .out_read_data, .out_was_read
  );

  task automatic report_mismatch(input string what);
    err_count++;
    $display("MISMATCH @%0d: %s", cycle_count, what);
  endtask

  // Framebuffer shadow and queue of expected replies
  class frame_scoreboard;
    logic [7:0]  shadow [FB_BYTES];
    read_reply_t pending [$];

    function new();
      foreach (shadow[i]) shadow[i] = '0;
    endfunction

    function void put_pixel(int px, int py, bit on);
      int at;
      px &= 255;
      py &= 255;
      if (px >= SCR_W || py >= SCR_H) return;
      at = px + (py >> 3) * SCR_W;
      if (on) shadow[at][py & 7] = 1'b1;
      else    shadow[at][py & 7] = 1'b0;
    endfunction

    function void glyph(int gx, int gy, int code, int sc);
      int idx;
      logic [7:0] bits;
      idx = (code >= pfde_pkg::GLYPH_FIRST && code <= pfde_pkg::GLYPH_LAST) ?
            code - pfde_pkg::GLYPH_FIRST : 0;
      if (sc == 0) sc = 1;
      for (int c = 0; c < 5; c++) begin
        bits = FONT[idx][39 - 8*c -: 8];
        for (int rw = 0; rw < 8; rw++)
          if (bits[rw])
            for (int dx = 0; dx < sc; dx++)
              for (int dy = 0; dy < sc; dy++)
                put_pixel(gx + c*sc + dx, gy + rw*sc + dy, 1'b1);
      end
    endfunction

    function void note_request(draw_cmd_t c);
      read_reply_t rep;
      int xe, ye;
      rep = '0;
      case (c.op)
        pfde_pkg::OP_READ: begin
          rep.rd = 1'b1;
          if (c.x < SCR_W && c.y < PAGES) rep.data = shadow[c.x + c.y * SCR_W];
        end
        pfde_pkg::OP_FILL: foreach (shadow[i]) shadow[i] = {8{c.color}};
        pfde_pkg::OP_PIXEL: put_pixel(c.x, c.y, c.color);
        pfde_pkg::OP_CHAR: glyph(c.x, c.y, c.code, c.sc);
        pfde_pkg::OP_RECT: begin
          xe = (c.x + c.w) & 255;
          ye = (c.y + c.h) & 255;
          for (int i = c.x; i <= xe; i++) begin
            put_pixel(i, c.y, 1'b1);
            put_pixel(i, ye, 1'b1);
          end
          for (int i = c.y; i <= ye; i++) begin
            put_pixel(c.x, i, 1'b1);
            put_pixel(xe, i, 1'b1);
          end
        end
        pfde_pkg::OP_HLINE: for (int i = c.x; i <= c.ex; i++) put_pixel(i, c.y, 1'b1);
        pfde_pkg::OP_CIRCLE: begin
          for (int dy = -int'(c.r); dy <= int'(c.r); dy++)
            for (int dx = -int'(c.r); dx <= int'(c.r); dx++)
              if (dx*dx + dy*dy <= int'(c.r)*int'(c.r))
                if (int'(c.x) + dx >= 0 && int'(c.y) + dy >= 0)
                  put_pixel(int'(c.x) + dx, int'(c.y) + dy, 1'b1);
        end
        default: ;
      endcase
      pending.push_back(rep);
    endfunction

    task check_result(logic [7:0] data, logic rd);
      read_reply_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected reply data=%02h rd=%0b", data, rd));
        return;
      end
      want = pending.pop_front();
      if (rd !== want.rd)
        report_mismatch($sformatf("was_read %0b, expected %0b", rd, want.rd));
      if (data !== want.data)
        report_mismatch($sformatf("read_data %02h, expected %02h", data, want.data));
    endtask
  endclass

  frame_scoreboard sb = new();

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("page_framebuffer_draw_engine_tb NOT OK");
      $finish;
    end
  end

  // Reply side: random stalls, one long hold-off on request
  initial begin : reply_sink
    int stall;
    bit hold_taken;
    hold_taken = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (long_hold && !hold_taken) begin
        stall = 3000;
        hold_taken = 1'b1;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      replies_seen++;
      if (out_was_read === 1'b1) reads_seen++;
      sb.check_result(out_read_data, out_was_read);
    end
  end

  // Issue one command and wait for it to be taken; then a random idle gap, none in a busy run
  task automatic send_cmd(input draw_cmd_t c, input bit busy_run);
    int gap;
    in_valid     <= 1'b1;
    in_operation <= c.op;
    in_pos_x     <= c.x;
    in_pos_y     <= c.y;
    in_extent_w  <= c.w;
    in_extent_h  <= c.h;
    in_end_x     <= c.ex;
    in_radius    <= c.r;
    in_char_code <= c.code;
    in_scale     <= c.sc;
    in_color     <= c.color;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_request(c);
    gap = busy_run ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic draw_cmd_t mk(logic [2:0] op, logic [7:0] x, logic [7:0] y);
    draw_cmd_t c;
    c = '0;
    c.op = op;
    c.x = x;
    c.y = y;
    return c;
  endfunction

  function automatic draw_cmd_t random_cmd();
    draw_cmd_t c;
    int pick;
    c.op    = pfde_pkg::OP_READ;
    c.x     = 8'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 135));
    c.y     = 8'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 70));
    c.w     = 8'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 40));
    c.h     = 8'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 30));
    c.ex    = 8'($urandom_range(0, 255));
    c.r     = 8'(($urandom_range(0, 40) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 12));
    c.code  = 8'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(32, 126));
    c.sc    = 8'(($urandom_range(0, 15) == 0) ? $urandom_range(5, 10) : $urandom_range(0, 4));
    c.color = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 32) begin
      c.op = pfde_pkg::OP_READ;
      if (pick < 26) c.y = 8'($urandom_range(0, PAGES - 1));
    end
    else if (pick < 35) c.op = pfde_pkg::OP_FILL;
    else if (pick < 53) c.op = pfde_pkg::OP_PIXEL;
    else if (pick < 67) c.op = pfde_pkg::OP_CHAR;
    else if (pick < 77) c.op = pfde_pkg::OP_RECT;
    else if (pick < 88) c.op = pfde_pkg::OP_HLINE;
    else if (pick < 97) c.op = pfde_pkg::OP_CIRCLE;
    else c.op = OP_NONE;
    return c;
  endfunction

  initial begin : stimulus
    draw_cmd_t c;
    draw_cmd_t dir [$];
    int run_left;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: corners, out-of-range reads, wraps, reversed spans, big sizes
    dir.push_back(mk(pfde_pkg::OP_READ, 8'd0, 8'd0));
    c = mk(pfde_pkg::OP_FILL, 8'd0, 8'd0); c.color = 1'b1; dir.push_back(c);
    dir.push_back(mk(pfde_pkg::OP_READ, 8'd127, 8'd7));
    dir.push_back(mk(pfde_pkg::OP_READ, 8'd128, 8'd0));
    dir.push_back(mk(pfde_pkg::OP_READ, 8'd0, 8'd8));
    dir.push_back(mk(pfde_pkg::OP_FILL, 8'd0, 8'd0));
    c = mk(pfde_pkg::OP_PIXEL, 8'd127, 8'd63); c.color = 1'b1; dir.push_back(c);
    c = mk(pfde_pkg::OP_PIXEL, 8'd255, 8'd255); c.color = 1'b1; dir.push_back(c);
    dir.push_back(mk(pfde_pkg::OP_READ, 8'd127, 8'd7));
    c = mk(pfde_pkg::OP_CHAR, 8'd250, 8'd250); c.code = 8'd0; c.sc = 8'd0; dir.push_back(c);
    c = mk(pfde_pkg::OP_CHAR, 8'd124, 8'd60); c.code = 8'd126; c.sc = 8'd1; dir.push_back(c);
    c = mk(pfde_pkg::OP_CHAR, 8'd252, 8'd2); c.code = 8'd33; c.sc = 8'd3; dir.push_back(c);
    c = mk(pfde_pkg::OP_CHAR, 8'd10, 8'd10); c.code = 8'd255; c.sc = 8'd255; dir.push_back(c);
    c = mk(pfde_pkg::OP_CHAR, 8'd20, 8'd20); c.code = 8'd127; c.sc = 8'd128; dir.push_back(c);
    c = mk(pfde_pkg::OP_RECT, 8'd250, 8'd250); c.w = 8'd5; c.h = 8'd5; dir.push_back(c);
    c = mk(pfde_pkg::OP_RECT, 8'd200, 8'd3); c.w = 8'd100; c.h = 8'd255; dir.push_back(c);
    c = mk(pfde_pkg::OP_RECT, 8'd100, 8'd40); c.w = 8'd155; c.h = 8'd215; dir.push_back(c);
    c = mk(pfde_pkg::OP_HLINE, 8'd120, 8'd5); c.ex = 8'd255; dir.push_back(c);
    c = mk(pfde_pkg::OP_HLINE, 8'd90, 8'd6); c.ex = 8'd40; dir.push_back(c);
    c = mk(pfde_pkg::OP_CIRCLE, 8'd0, 8'd0); c.r = 8'd3; dir.push_back(c);
    c = mk(pfde_pkg::OP_CIRCLE, 8'd60, 8'd30); c.r = 8'd0; dir.push_back(c);
    c = mk(pfde_pkg::OP_CIRCLE, 8'd250, 8'd10); c.r = 8'd128; dir.push_back(c);
    c = mk(pfde_pkg::OP_CIRCLE, 8'd255, 8'd255); c.r = 8'd127; dir.push_back(c);
    dir.push_back(mk(OP_NONE, 8'd255, 8'd255));
    dir.push_back(mk(pfde_pkg::OP_READ, 8'd255, 8'd255));
    foreach (dir[i]) send_cmd(dir[i], 1'b0);

    // Random: stretches with no gaps, a long reply hold-off, a full drain
    run_left = 0;
    for (int n = 0; n < RAND_CMDS; n++) begin
      if (run_left == 0 && $urandom_range(0, 30) == 0) run_left = $urandom_range(5, 20);
      if (n == 300) long_hold = 1'b1;
      if (n == 600) begin
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
      end
      send_cmd(random_cmd(), run_left > 0);
      if (run_left > 0) run_left--;
    end
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Ran %0d commands of every opcode incl. wraps, clipping and big glyphs/discs;",
             dir.size() + RAND_CMDS);
    $display("%0d replies checked, %0d of them framebuffer reads.", replies_seen, reads_seen);
    if (err_count == 0 && sb.pending.size() == 0)
      $display("page_framebuffer_draw_engine_tb OK");
    else
      $display("page_framebuffer_draw_engine_tb NOT OK");
    $finish;
  end
endmodule
